### sv/clipped_rect_fill_raster_core_assert.svh
// Assertion macros, sampled on clk and disabled while rst is high.
`ifndef CLIPPED_RECT_FILL_RASTER_CORE_ASSERT_SVH
`define CLIPPED_RECT_FILL_RASTER_CORE_ASSERT_SVH

// same-cycle implication
`define CRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/crf_pkg.sv
`timescale 1ns / 1ps
package crf_pkg;

  localparam int COORD_W     = 24;
  localparam int BOX_W       = 26;
  localparam int COLOR_W     = 16;
  localparam int DEPTH_OUT_W = 5;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [2:0] {
    ACT_QUAD   = 3'd0,
    ACT_TEXT   = 3'd1,
    ACT_IMAGE  = 3'd2,
    ACT_BOUNDS = 3'd3,
    ACT_PUSH   = 3'd4,
    ACT_POP    = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_READ   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_SKIP    = 2'd1,
    ST_FULL    = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_VX   = 3'd0,
    REG_VY   = 3'd1,
    REG_VW   = 3'd2,
    REG_VH   = 3'd3,
    REG_COLS = 3'd4,
    REG_ROWS = 3'd5
  } reg_index_t;

  typedef enum logic [4:0] {
    S_BOOT,
    S_IDLE,
    S_DECODE,
    S_CLIP_RD,
    S_CLIP_ACC,
    S_CHECK,
    S_MAP_SUB,
    S_MAP_MUL,
    S_DIV,
    S_MAP_STORE,
    S_SPAN,
    S_FILL,
    S_RD_MEM,
    S_RD_CAP,
    S_WIPE,
    S_FINISH
  } state_t;

  typedef struct packed {
    action_t                    action;
    logic signed [COORD_W-1:0]  rect_left;
    logic signed [COORD_W-1:0]  rect_top;
    logic signed [COORD_W-1:0]  rect_width;
    logic signed [COORD_W-1:0]  rect_height;
    logic signed [COLOR_W-1:0]  color_red;
    logic signed [COLOR_W-1:0]  color_green;
    logic signed [COLOR_W-1:0]  color_blue;
    logic signed [COLOR_W-1:0]  color_alpha;
    logic [7:0]                 read_column;
    logic [7:0]                 read_row;
  } cmd_item_t;

  typedef struct packed {
    status_t                  status;
    logic [7:0]               pixel_red;
    logic [7:0]               pixel_green;
    logic [7:0]               pixel_blue;
    logic [7:0]               pixel_alpha;
    logic [DEPTH_OUT_W-1:0]   clip_depth;
  } rsp_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vw;
    logic signed [COORD_W-1:0] vh;
    logic [8:0]                cols;
    logic [8:0]                rows;
  } cfg_t;

  typedef struct packed {
    logic signed [BOX_W-1:0] l;
    logic signed [BOX_W-1:0] t;
    logic signed [BOX_W-1:0] r;
    logic signed [BOX_W-1:0] b;
  } box_t;

  typedef struct packed {
    logic    load_item;
    logic    clip_init;
    logic    clip_step;
    logic    clip_cut;
    logic    push_wr;
    logic    pop;
    logic    depth_clear;
    logic    map_sub;
    logic    map_mul;
    logic    div_step;
    logic    map_store;
    logic    fill_init;
    logic    fill_step;
    logic    sweep_init;
    logic    sweep_step;
    logic    rd_addr;
    logic    rd_cap;
    logic    set_status;
    status_t status;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    draw_ok;
    logic    stack_full;
    logic    stack_empty;
    logic    clip_done;
    logic    acc_visible;
    logic    map_last;
    logic    div_last;
    logic    span_ok;
    logic    fill_last;
    logic    sweep_last;
    logic    read_outside;
    logic    out_free;
  } dp_stat_t;

  function automatic box_t box_cut(box_t a, box_t b);
    box_t o;
    o.l = (a.l > b.l) ? a.l : b.l;
    o.t = (a.t > b.t) ? a.t : b.t;
    o.r = (a.r < b.r) ? a.r : b.r;
    o.b = (a.b < b.b) ? a.b : b.b;
    if (o.r <= o.l || o.b <= o.t) begin
      o.r = o.l;
      o.b = o.t;
    end
    return o;
  endfunction

  function automatic logic box_visible(box_t a);
    return (a.r > a.l) && (a.b > a.t);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat24(logic signed [BOX_W-1:0] v);
    logic signed [COORD_W-1:0] o;
    if (v > 26'sd8388607) begin
      o = 24'sh7FFFFF;
    end else if (v < -26'sd8388608) begin
      o = 24'sh800000;
    end else begin
      o = v[COORD_W-1:0];
    end
    return o;
  endfunction

  function automatic logic [7:0] chan_byte(logic signed [COLOR_W-1:0] c);
    logic [12:0] cl;
    logic [20:0] p;
    if (c < 16'sd0) begin
      cl = 13'd0;
    end else if (c > 16'sd4096) begin
      cl = 13'd4096;
    end else begin
      cl = c[12:0];
    end
    p = 21'(cl) * 21'd255 + 21'd2048;
    return p[19:12];
  endfunction

endpackage

### sv/crf_ram.sv
`timescale 1ns / 1ps
module crf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/crf_cfg.sv
`timescale 1ns / 1ps
module crf_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [crf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [crf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output crf_pkg::cfg_t                    cfg
);
  import crf_pkg::*;

  reg_index_t idx;

  assign idx    = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vx   <= '0;
      cfg.vy   <= '0;
      cfg.vw   <= 24'sd65536;
      cfg.vh   <= 24'sd65536;
      cfg.cols <= 9'd256;
      cfg.rows <= 9'd256;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_VX:   cfg.vx   <= pwdata[COORD_W-1:0];
        REG_VY:   cfg.vy   <= pwdata[COORD_W-1:0];
        REG_VW:   cfg.vw   <= pwdata[COORD_W-1:0];
        REG_VH:   cfg.vh   <= pwdata[COORD_W-1:0];
        REG_COLS: cfg.cols <= pwdata[8:0];
        REG_ROWS: cfg.rows <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VX:   prdata = CFG_DATA_W'($unsigned(cfg.vx));
      REG_VY:   prdata = CFG_DATA_W'($unsigned(cfg.vy));
      REG_VW:   prdata = CFG_DATA_W'($unsigned(cfg.vw));
      REG_VH:   prdata = CFG_DATA_W'($unsigned(cfg.vh));
      REG_COLS: prdata = CFG_DATA_W'(cfg.cols);
      REG_ROWS: prdata = CFG_DATA_W'(cfg.rows);
      default:  prdata = '0;
    endcase
  end

endmodule

### sv/crf_ctrl.sv
`timescale 1ns / 1ps
module crf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  crf_pkg::dp_stat_t  stat,
  output crf_pkg::ctl_cmd_t  ctl
);
  import crf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = 1'b1;
    case (state)
      S_BOOT: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.action)
          ACT_QUAD, ACT_IMAGE, ACT_BOUNDS: begin
            if (stat.draw_ok) begin
              ctl.clip_init = 1'b1;
              state_next    = S_CLIP_RD;
            end else begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_SKIP;
              state_next     = S_FINISH;
            end
          end
          ACT_PUSH: begin
            if (stat.stack_full) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_FULL;
              state_next     = S_FINISH;
            end else begin
              ctl.clip_init = 1'b1;
              state_next    = S_CLIP_RD;
            end
          end
          ACT_POP: begin
            if (stat.stack_empty) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_SKIP;
            end else begin
              ctl.pop = 1'b1;
            end
            state_next = S_FINISH;
          end
          ACT_CLEAR: begin
            ctl.sweep_init  = 1'b1;
            ctl.depth_clear = 1'b1;
            state_next      = S_WIPE;
          end
          ACT_READ: begin
            if (stat.read_outside) begin
              ctl.set_status = 1'b1;
              ctl.status     = ST_OUTSIDE;
              state_next     = S_FINISH;
            end else begin
              ctl.rd_addr = 1'b1;
              state_next  = S_RD_MEM;
            end
          end
          default: begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_SKIP;
            state_next     = S_FINISH;
          end
        endcase
      end
      S_CLIP_RD: begin
        if (stat.clip_done) begin
          ctl.clip_cut = 1'b1;
          state_next   = S_CHECK;
        end else begin
          state_next = S_CLIP_ACC;
        end
      end
      S_CLIP_ACC: begin
        ctl.clip_step = 1'b1;
        state_next    = S_CLIP_RD;
      end
      S_CHECK: begin
        if (stat.action == ACT_PUSH) begin
          ctl.push_wr = 1'b1;
          state_next  = S_FINISH;
        end else if (!stat.acc_visible) begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_SKIP;
          state_next     = S_FINISH;
        end else begin
          state_next = S_MAP_SUB;
        end
      end
      S_MAP_SUB: begin
        ctl.map_sub = 1'b1;
        state_next  = S_MAP_MUL;
      end
      S_MAP_MUL: begin
        ctl.map_mul = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) state_next = S_MAP_STORE;
      end
      S_MAP_STORE: begin
        ctl.map_store = 1'b1;
        state_next    = stat.map_last ? S_SPAN : S_MAP_SUB;
      end
      S_SPAN: begin
        if (stat.span_ok) begin
          ctl.fill_init = 1'b1;
          state_next    = S_FILL;
        end else begin
          ctl.set_status = 1'b1;
          ctl.status     = ST_SKIP;
          state_next     = S_FINISH;
        end
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        if (stat.fill_last) state_next = S_FINISH;
      end
      S_RD_MEM: begin
        state_next = S_RD_CAP;
      end
      S_RD_CAP: begin
        ctl.rd_cap = 1'b1;
        state_next = S_FINISH;
      end
      S_WIPE: begin
        ctl.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/crf_dpath.sv
`timescale 1ns / 1ps
module crf_dpath #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int CLIP_DEPTH  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  crf_pkg::cfg_t      cfg,
  input  crf_pkg::cmd_item_t cmd,
  input  crf_pkg::ctl_cmd_t  ctl,
  output crf_pkg::dp_stat_t  stat,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output crf_pkg::rsp_item_t rsp
);
  import crf_pkg::*;

  localparam int MAXD = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int SW   = $clog2(MAXD + 1);
  localparam int FD   = MAX_COLUMNS * MAX_ROWS;
  localparam int FAW  = (FD > 1) ? $clog2(FD) : 1;
  localparam int DW   = $clog2(CLIP_DEPTH + 1);
  localparam int SAW  = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
  localparam int QCW  = $clog2(SW + 1);
  localparam int NW   = COORD_W + SW;

  cmd_item_t                 item;
  status_t                   status_r;
  logic [31:0]               pixel;
  logic [DW-1:0]             depth;
  logic [DW-1:0]             clip_idx;
  box_t                      acc;
  logic [1:0]                map_idx;
  logic signed [BOX_W:0]     delta;
  logic                      zero_f;
  logic                      full_f;
  logic [NW-1:0]             dv;
  logic [QCW-1:0]            div_cnt;
  logic [SW-1:0]             bound_q [4];
  logic [SW-1:0]             fill_x;
  logic [SW-1:0]             fill_y;
  logic [FAW-1:0]            row_base;
  logic [FAW-1:0]            sweep_addr;
  logic [FAW-1:0]            rd_addr_q;

  logic [SW-1:0]             cols;
  logic [SW-1:0]             rows;
  box_t                      vp_box;
  box_t                      cmd_box;
  box_t                      stk_box;
  logic [4*COORD_W-1:0]      stk_rdata;
  logic [4*COORD_W-1:0]      stk_wdata;
  logic [31:0]               frame_rdata;
  logic [31:0]               frame_wdata;
  logic [FAW-1:0]            frame_waddr;
  logic                      frame_we;
  logic [31:0]               fill_word;

  logic signed [BOX_W-1:0]   m_v;
  logic signed [COORD_W-1:0] m_org;
  logic signed [COORD_W-1:0] m_ext;
  logic [SW-1:0]             m_size;
  logic signed [BOX_W:0]     delta_next;
  logic [NW-1:0]             prod;
  logic [COORD_W:0]          trial;
  logic                      ge;
  logic [COORD_W:0]          rem_next;
  logic [SW:0]               low_sh;
  logic [SW-1:0]             quot;
  logic [SW-1:0]             map_res;
  logic [2*SW-1:0]           base_prod;
  logic [SW+8:0]             rd_lin;

  assign cols = (32'(cfg.cols) > MAX_COLUMNS) ? SW'(MAX_COLUMNS) : SW'(cfg.cols);
  assign rows = (32'(cfg.rows) > MAX_ROWS) ? SW'(MAX_ROWS) : SW'(cfg.rows);

  assign vp_box.l  = BOX_W'(cfg.vx);
  assign vp_box.t  = BOX_W'(cfg.vy);
  assign vp_box.r  = BOX_W'(cfg.vx) + BOX_W'(cfg.vw);
  assign vp_box.b  = BOX_W'(cfg.vy) + BOX_W'(cfg.vh);
  assign cmd_box.l = BOX_W'(item.rect_left);
  assign cmd_box.t = BOX_W'(item.rect_top);
  assign cmd_box.r = BOX_W'(item.rect_left) + BOX_W'(item.rect_width);
  assign cmd_box.b = BOX_W'(item.rect_top) + BOX_W'(item.rect_height);

  assign stk_box.l = BOX_W'($signed(stk_rdata[4*COORD_W-1:3*COORD_W]));
  assign stk_box.t = BOX_W'($signed(stk_rdata[3*COORD_W-1:2*COORD_W]));
  assign stk_box.r = BOX_W'($signed(stk_rdata[2*COORD_W-1:COORD_W]));
  assign stk_box.b = BOX_W'($signed(stk_rdata[COORD_W-1:0]));
  assign stk_wdata = {sat24(acc.l), sat24(acc.t), sat24(acc.r), sat24(acc.b)};

  assign fill_word = {chan_byte(item.color_alpha), chan_byte(item.color_blue),
                      chan_byte(item.color_green), chan_byte(item.color_red)};

  always_comb begin
    case (map_idx)
      2'd0: begin m_v = acc.l; m_org = cfg.vx; m_ext = cfg.vw; m_size = cols; end
      2'd1: begin m_v = acc.t; m_org = cfg.vy; m_ext = cfg.vh; m_size = rows; end
      2'd2: begin m_v = acc.r; m_org = cfg.vx; m_ext = cfg.vw; m_size = cols; end
      default: begin m_v = acc.b; m_org = cfg.vy; m_ext = cfg.vh; m_size = rows; end
    endcase
  end

  assign delta_next = (BOX_W+1)'(m_v) - (BOX_W+1)'(m_org);
  assign prod       = NW'(delta[COORD_W-1:0]) * NW'(m_size);
  assign trial      = {dv[NW-1:SW], dv[SW-1]};
  assign ge         = trial >= (COORD_W+1)'($unsigned(m_ext));
  assign rem_next   = ge ? trial - (COORD_W+1)'($unsigned(m_ext)) : trial;
  assign low_sh     = {dv[SW-1:0], ge};
  assign quot       = dv[SW-1:0];

  always_comb begin
    if (zero_f) begin
      map_res = '0;
    end else if (full_f) begin
      map_res = m_size;
    end else if (map_idx[1] && (|dv[NW-1:SW])) begin
      map_res = quot + SW'(1);
    end else begin
      map_res = quot;
    end
  end

  assign base_prod = (2*SW)'(bound_q[1]) * (2*SW)'(cols);
  assign rd_lin    = (SW+9)'(item.read_row) * (SW+9)'(cols) + (SW+9)'(item.read_column);

  assign frame_we    = ctl.fill_step || ctl.sweep_step;
  assign frame_waddr = ctl.sweep_step ? sweep_addr : row_base + FAW'(fill_x);
  assign frame_wdata = ctl.sweep_step ? 32'd0 : fill_word;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item     <= cmd;
      status_r <= ST_DONE;
      pixel    <= '0;
    end
    if (ctl.set_status) status_r <= ctl.status;
    if (ctl.rd_cap) pixel <= frame_rdata;
    if (ctl.rd_addr) rd_addr_q <= FAW'(rd_lin);
    if (ctl.clip_init) begin
      acc      <= vp_box;
      clip_idx <= '0;
    end
    if (ctl.clip_step) begin
      acc      <= box_cut(acc, stk_box);
      clip_idx <= clip_idx + DW'(1);
    end
    if (ctl.clip_cut) begin
      acc     <= box_cut(cmd_box, acc);
      map_idx <= '0;
    end
    if (ctl.map_sub) begin
      delta  <= delta_next;
      zero_f <= delta_next <= 0;
      full_f <= delta_next >= (BOX_W+1)'(m_ext);
    end
    if (ctl.map_mul) begin
      dv      <= prod;
      div_cnt <= '0;
    end
    if (ctl.div_step) begin
      dv      <= {rem_next[COORD_W-1:0], low_sh[SW-1:0]};
      div_cnt <= div_cnt + QCW'(1);
    end
    if (ctl.map_store) begin
      bound_q[map_idx] <= map_res;
      map_idx          <= map_idx + 2'd1;
    end
    if (ctl.fill_init) begin
      fill_x   <= bound_q[0];
      fill_y   <= bound_q[1];
      row_base <= FAW'(base_prod);
    end
    if (ctl.fill_step) begin
      if (fill_x == bound_q[2] - SW'(1)) begin
        fill_x   <= bound_q[0];
        fill_y   <= fill_y + SW'(1);
        row_base <= row_base + FAW'(cols);
      end else begin
        fill_x <= fill_x + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      sweep_addr <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (ctl.push_wr) depth <= depth + DW'(1);
      if (ctl.pop) depth <= depth - DW'(1);
      if (ctl.depth_clear) depth <= '0;
      if (ctl.sweep_init) sweep_addr <= '0;
      if (ctl.sweep_step) sweep_addr <= sweep_addr + FAW'(1);
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.status      <= status_r;
      rsp.pixel_red   <= pixel[7:0];
      rsp.pixel_green <= pixel[15:8];
      rsp.pixel_blue  <= pixel[23:16];
      rsp.pixel_alpha <= pixel[31:24];
      rsp.clip_depth  <= DEPTH_OUT_W'(depth);
    end
  end

  assign stat.action       = item.action;
  assign stat.draw_ok      = (cols != '0) && (rows != '0) && (cfg.vw > 0) && (cfg.vh > 0) &&
                             (item.rect_width > 0) && (item.rect_height > 0) &&
                             (chan_byte(item.color_alpha) != 8'd0);
  assign stat.stack_full   = depth == DW'(CLIP_DEPTH);
  assign stat.stack_empty  = depth == '0;
  assign stat.clip_done    = clip_idx == depth;
  assign stat.acc_visible  = box_visible(acc);
  assign stat.map_last     = map_idx == 2'd3;
  assign stat.div_last     = div_cnt == QCW'(SW - 1);
  assign stat.span_ok      = (bound_q[2] > bound_q[0]) && (bound_q[3] > bound_q[1]);
  assign stat.fill_last    = (fill_x == bound_q[2] - SW'(1)) && (fill_y == bound_q[3] - SW'(1));
  assign stat.sweep_last   = sweep_addr == FAW'(FD - 1);
  assign stat.read_outside = (32'(item.read_column) >= 32'(cols)) ||
                             (32'(item.read_row) >= 32'(rows));
  assign stat.out_free     = !rsp_valid || !rsp_stall;

  crf_ram #(.WIDTH(4*COORD_W), .DEPTH(CLIP_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ctl.push_wr),
    .waddr (depth[SAW-1:0]),
    .wdata (stk_wdata),
    .raddr (clip_idx[SAW-1:0]),
    .rdata (stk_rdata)
  );

  crf_ram #(.WIDTH(32), .DEPTH(FD)) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (rd_addr_q),
    .rdata (frame_rdata)
  );

endmodule

### sv/clipped_rect_fill_raster_core.sv
`timescale 1ns / 1ps
// channel   | signals                          | dir | transaction
// ----------+----------------------------------+-----+-------------------------------
// command   | cmd_valid, cmd_stall, cmd        | in  | one draw, clip, clear or read
// response  | rsp_valid, rsp_stall, rsp        | out | one status per command
// config    | psel, penable, pwrite, paddr ... | in  | APB register write or read
//
// One command at a time, acceptance to next acceptance. A draw cuts the viewport by the
// stacked clips and its own box, maps the edges to pixels by shift-subtract division and
// fills the covered pixels, one pixel a cycle; a push stacks the same cut. Pop, text,
// early skips and reads set a status or fetch one store word. Clear and the reset pass
// sweep all MAX_COLUMNS x MAX_ROWS words, one a cycle; cmd_stall stays high during the reset pass.
// A held response stalls only the finish of the following command.
`include "clipped_rect_fill_raster_core_assert.svh"
module clipped_rect_fill_raster_core #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int CLIP_DEPTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  crf_pkg::cmd_item_t             cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output crf_pkg::rsp_item_t             rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [crf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [crf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import crf_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t ctl;
  dp_stat_t stat;

  crf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  crf_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CLIP_DEPTH  (CLIP_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `CRF_ASSERT_NXT(a_accept_then_busy, cmd_valid && !cmd_stall, cmd_stall, "command taken while busy")
  `CRF_ASSERT_IMP(a_load_when_free, ctl.out_load, !rsp_valid || !rsp_stall, "response overwritten")
  `CRF_ASSERT_IMP(a_outside_zero, rsp_valid && rsp.status == ST_OUTSIDE, rsp.pixel_red == 8'd0 && rsp.pixel_green == 8'd0 && rsp.pixel_blue == 8'd0 && rsp.pixel_alpha == 8'd0, "pixel bytes on outside read")
  `CRF_ASSERT_IMP(a_full_depth, rsp_valid && rsp.status == ST_FULL, rsp.clip_depth == DEPTH_OUT_W'(CLIP_DEPTH), "full status below depth")

endmodule

### test/crf_checker.sv
`timescale 1ns / 1ps
module crf_checker
  import crf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  cmd_item_t             cmd,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  rsp_item_t             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    errors,
  output int                    pending
);

  localparam int NCOL = 256;
  localparam int NROW = 256;
  localparam int NCLIP = 16;

  typedef struct {
    longint l, t, r, b;
  } area_t;

  bit [31:0]  pixels [0:NCOL*NROW-1];
  longint     stk_l [NCLIP];
  longint     stk_t [NCLIP];
  longint     stk_r [NCLIP];
  longint     stk_b [NCLIP];
  int         depth;
  longint     vx, vy, vw, vh;
  int         cols, rows;
  rsp_item_t  awaited [$];

  function automatic area_t overlap(area_t a, area_t b);
    area_t o;
    o.l = (a.l > b.l) ? a.l : b.l;
    o.t = (a.t > b.t) ? a.t : b.t;
    o.r = (a.r < b.r) ? a.r : b.r;
    o.b = (a.b < b.b) ? a.b : b.b;
    if (o.r <= o.l || o.b <= o.t) begin
      o.r = o.l;
      o.b = o.t;
    end
    return o;
  endfunction

  function automatic area_t scissor();
    area_t c;
    area_t e;
    c.l = vx;
    c.t = vy;
    c.r = vx + vw;
    c.b = vy + vh;
    for (int i = 0; i < depth; i++) begin
      e.l = stk_l[i];
      e.t = stk_t[i];
      e.r = stk_r[i];
      e.b = stk_b[i];
      c = overlap(c, e);
    end
    return c;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint to_px(longint v, longint org, longint ext, longint size, bit up);
    longint num;
    longint q;
    longint rm;
    num = (v - org) * size;
    q = num / ext;
    rm = num % ext;
    if (rm != 0 && !up && num < 0) q--;
    if (rm != 0 && up && num > 0) q++;
    if (q < 0) q = 0;
    if (q > size) q = size;
    return q;
  endfunction

  function automatic bit [7:0] to_byte(logic signed [COLOR_W-1:0] c);
    longint x;
    x = longint'(c);
    if (x < 0) x = 0;
    if (x > 4096) x = 4096;
    return 8'((x * 255 + 2048) >> 12);
  endfunction

  function automatic area_t cmd_area(cmd_item_t c);
    area_t a;
    a.l = longint'(c.rect_left);
    a.t = longint'(c.rect_top);
    a.r = a.l + longint'(c.rect_width);
    a.b = a.t + longint'(c.rect_height);
    return a;
  endfunction

  function automatic status_t paint_area(cmd_item_t c);
    area_t   a;
    longint  x0, x1, y0, y1;
    int      ec, er;
    bit [31:0] word;
    ec = (cols > NCOL) ? NCOL : cols;
    er = (rows > NROW) ? NROW : rows;
    if (ec == 0 || er == 0 || vw <= 0 || vh <= 0) return ST_SKIP;
    if (c.color_alpha <= 0) return ST_SKIP;
    a = cmd_area(c);
    if (!(a.r > a.l && a.b > a.t)) return ST_SKIP;
    a = overlap(a, scissor());
    if (!(a.r > a.l && a.b > a.t)) return ST_SKIP;
    x0 = to_px(a.l, vx, vw, ec, 1'b0);
    y0 = to_px(a.t, vy, vh, er, 1'b0);
    x1 = to_px(a.r, vx, vw, ec, 1'b1);
    y1 = to_px(a.b, vy, vh, er, 1'b1);
    if (x1 <= x0 || y1 <= y0) return ST_SKIP;
    word = {to_byte(c.color_alpha), to_byte(c.color_blue),
            to_byte(c.color_green), to_byte(c.color_red)};
    if (word[31:24] == 8'd0) return ST_SKIP;
    for (longint y = y0; y < y1; y++)
      for (longint x = x0; x < x1; x++)
        pixels[y * ec + x] = word;
    return ST_DONE;
  endfunction

  function automatic rsp_item_t apply_cmd(cmd_item_t c);
    rsp_item_t o;
    area_t     p;
    int        ec, er;
    bit [31:0] word;
    o = '0;
    o.status = ST_DONE;
    case (c.action)
      ACT_QUAD, ACT_IMAGE, ACT_BOUNDS: o.status = paint_area(c);
      ACT_TEXT: o.status = ST_SKIP;
      ACT_PUSH: begin
        if (depth >= NCLIP) begin
          o.status = ST_FULL;
        end else begin
          p = overlap(cmd_area(c), scissor());
          stk_l[depth] = clamp24(p.l);
          stk_t[depth] = clamp24(p.t);
          stk_r[depth] = clamp24(p.r);
          stk_b[depth] = clamp24(p.b);
          depth++;
        end
      end
      ACT_POP: begin
        if (depth == 0) o.status = ST_SKIP;
        else depth--;
      end
      ACT_CLEAR: begin
        foreach (pixels[i]) pixels[i] = '0;
        depth = 0;
      end
      default: begin
        ec = (cols > NCOL) ? NCOL : cols;
        er = (rows > NROW) ? NROW : rows;
        if (int'(c.read_column) >= ec || int'(c.read_row) >= er) begin
          o.status = ST_OUTSIDE;
        end else begin
          word = pixels[int'(c.read_row) * ec + int'(c.read_column)];
          {o.pixel_alpha, o.pixel_blue, o.pixel_green, o.pixel_red} = word;
        end
      end
    endcase
    o.clip_depth = 5'(depth);
    return o;
  endfunction

  initial begin
    foreach (pixels[i]) pixels[i] = '0;
    depth = 0;
    vx = 0;
    vy = 0;
    vw = 65536;
    vh = 65536;
    cols = 256;
    rows = 256;
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rsp_item_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t: response with none outstanding, got %p", $time, rsp);
          errors++;
        end else begin
          e = awaited.pop_front();
          if (rsp.status !== e.status) begin
            $display("%0t: status expected %s got %s", $time, e.status.name(),
                     rsp.status.name());
            errors++;
          end
          if (rsp.pixel_red !== e.pixel_red) begin
            $display("%0t: red expected %0d got %0d", $time, e.pixel_red, rsp.pixel_red);
            errors++;
          end
          if (rsp.pixel_green !== e.pixel_green) begin
            $display("%0t: green expected %0d got %0d", $time, e.pixel_green,
                     rsp.pixel_green);
            errors++;
          end
          if (rsp.pixel_blue !== e.pixel_blue) begin
            $display("%0t: blue expected %0d got %0d", $time, e.pixel_blue, rsp.pixel_blue);
            errors++;
          end
          if (rsp.pixel_alpha !== e.pixel_alpha) begin
            $display("%0t: alpha expected %0d got %0d", $time, e.pixel_alpha,
                     rsp.pixel_alpha);
            errors++;
          end
          if (rsp.clip_depth !== e.clip_depth) begin
            $display("%0t: clip depth expected %0d got %0d", $time, e.clip_depth,
                     rsp.clip_depth);
            errors++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) awaited = {awaited, apply_cmd(cmd)};
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[4:2]))
          REG_VX:   vx = longint'($signed(pwdata[23:0]));
          REG_VY:   vy = longint'($signed(pwdata[23:0]));
          REG_VW:   vw = longint'($signed(pwdata[23:0]));
          REG_VH:   vh = longint'($signed(pwdata[23:0]));
          REG_COLS: cols = int'(pwdata[8:0]);
          REG_ROWS: rows = int'(pwdata[8:0]);
          default: ;
        endcase
      end
      pending = awaited.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import crf_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_item_t             cmd = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_item_t             rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors, pending;

  int     idle_pct = 0;
  int     stall_pct = 0;
  longint vx = 0, vy = 0, vw = 65536, vh = 65536;
  int     ec = 256, er = 256;
  int     n_sent = 0, n_draw = 0, n_push = 0, n_read = 0, n_clear = 0;

  clipped_rect_fill_raster_core DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  crf_checker u_checker (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #100ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic cmd_item_t mk(action_t a, longint l, longint t, longint w, longint h,
                                   int r, int g, int b, int al, int col, int row);
    cmd_item_t c;
    c.action = a;
    c.rect_left = 24'(l);
    c.rect_top = 24'(t);
    c.rect_width = 24'(w);
    c.rect_height = 24'(h);
    c.color_red = 16'(r);
    c.color_green = 16'(g);
    c.color_blue = 16'(b);
    c.color_alpha = 16'(al);
    c.read_column = 8'(col);
    c.read_row = 8'(row);
    return c;
  endfunction

  task automatic send(cmd_item_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    n_sent++;
    case (c.action)
      ACT_QUAD, ACT_IMAGE, ACT_BOUNDS: n_draw++;
      ACT_PUSH: n_push++;
      ACT_READ: n_read++;
      ACT_CLEAR: n_clear++;
      default: ;
    endcase
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(reg_index_t idx, longint v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(longint x, longint y, longint w, longint h, int c, int r);
    reg_write(REG_VX, x);
    reg_write(REG_VY, y);
    reg_write(REG_VW, w);
    reg_write(REG_VH, h);
    reg_write(REG_COLS, c);
    reg_write(REG_ROWS, r);
    vx = longint'($signed(24'(x)));
    vy = longint'($signed(24'(y)));
    vw = longint'($signed(24'(w)));
    vh = longint'($signed(24'(h)));
    ec = (c > 256) ? 256 : c;
    er = (r > 256) ? 256 : r;
  endtask

  function automatic int rand_colour();
    if ($urandom_range(3) == 0) return int'($urandom_range(65535));
    return int'($urandom_range(4300)) - 100;
  endfunction

  function automatic cmd_item_t rand_rect(action_t a);
    longint sw, sh, l, t, w, h;
    bit     raw_ok;
    sw = (vw > 0) ? vw : 65536;
    sh = (vh > 0) ? vh : 65536;
    raw_ok = (ec * er <= 256);
    l = vx + longint'($urandom_range(32'(sw * 9 / 8))) - sw / 8;
    t = vy + longint'($urandom_range(32'(sh * 9 / 8))) - sh / 8;
    w = 1 + longint'($urandom_range(32'(sw / 8)));
    h = 1 + longint'($urandom_range(32'(sh / 8)));
    case ($urandom_range(9))
      0: w = -longint'($urandom_range(3));
      1: h = -longint'($urandom_range(3));
      2: if (raw_ok) begin
        l = longint'($urandom);
        t = longint'($urandom);
        w = longint'($urandom);
        h = longint'($urandom);
      end
      default: ;
    endcase
    return mk(a, l, t, w, h, rand_colour(), rand_colour(), rand_colour(),
              ($urandom_range(4) == 0) ? rand_colour() : int'($urandom_range(4096)),
              0, 0);
  endfunction

  task automatic random_run(int count);
    int        k;
    cmd_item_t c;
    for (int i = 0; i < count; i++) begin
      k = int'($urandom_range(999));
      if (k < 400) begin
        send(rand_rect(action_t'($urandom_range(3))));
      end else if (k < 650) begin
        if ($urandom_range(9) == 0) c = mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                                           int'($urandom), int'($urandom));
        else c = mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0,
                    int'($urandom_range(ec + 1)), int'($urandom_range(er + 1)));
        send(c);
      end else if (k < 770) begin
        if ($urandom_range(5) == 0) begin
          repeat (18) send(rand_rect(ACT_PUSH));
          i += 17;
        end else begin
          send(rand_rect(ACT_PUSH));
        end
      end else if (k < 890) begin
        send(mk(ACT_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      end else if (k < 995) begin
        c = rand_rect(ACT_TEXT);
        c.read_column = 8'($urandom);
        c.read_row = 8'($urandom);
        send(c);
      end else begin
        send(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);

    setup(0, 0, 65536, 65536, 256, 256);
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 65536, 65536, 4096, 4096, 4096, 4096, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 255, 255));
    send(mk(ACT_TEXT, 0, 0, 256, 256, 4096, 4096, 4096, 4096, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 256, 256, 4096, 0, 0, 0, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 256, 256, 4096, 0, 0, -32768, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 0, 256, 4096, 0, 0, 4096, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 256, -8388608, 4096, 0, 0, 4096, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 256, 256, 4096, 0, 0, 8, 0, 0));
    send(mk(ACT_IMAGE, 512, 512, 768, 768, -32768, 32767, 2048, 4096, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 3, 3));
    send(mk(ACT_BOUNDS, 300, 300, 100, 600, 16, 4095, 1000, 17, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2));
    send(mk(ACT_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_PUSH, 2560, 2560, 5120, 5120, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_PUSH, 0, 0, 256, 256, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUAD, 0, 0, 65536, 65536, 100, 100, 100, 4096, 0, 0));
    send(mk(ACT_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUAD, -8388608, -8388608, 8388607, 8388607, 200, 0, 0, 32767, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 10, 10));
    send(mk(ACT_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 3, 3));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      case (ph)
        0: setup(0, 0, 65536, 65536, 256, 256);
        1: setup(0, 0, 4096, 4096, 16, 16);
        2: setup(-2560, 1280, 3000, 5000, 13, 7);
        3: setup(0, 0, -256, 65536, 16, 16);
        4: setup(0, 0, 65536, 0, 16, 16);
        5: setup(0, 0, 4096, 4096, 0, 16);
        6: setup(-8388608, 8388607, 8388607, 8388607, 1, 1);
        default: setup(-1000, -1000, 65536, 65536, 511, 511);
      endcase
      random_run(128);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d commands over 9 register settings: %0d fills, %0d clip pushes,",
             n_sent, n_draw, n_push);
    $display("%0d pixel reads and %0d clears, with sender gaps and response stalls",
             n_read, n_clear);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
